>>> rtl/core/dcvr_pkg.sv
// Shared widths, control struct and output saturation for the disc collision response.
// No dependencies; imported by every module of the block.
package dcvr_pkg;

  localparam int unsigned FIELD_W   = 24;
  localparam int unsigned MASS_W    = 16;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned IN_DATA_W = 8 * FIELD_W + 4 * MASS_W;
  localparam int unsigned OUT_DATA_W = 4 * FIELD_W;
  localparam int unsigned NUM_W     = 84;
  localparam int unsigned DEN_W     = 59;
  localparam int unsigned QUO_W     = FIELD_W;
  localparam int unsigned DIV_STEPS = QUO_W;

  localparam logic [CFG_W-1:0] RESTITUTION_RESET = 9'd128;
  localparam logic [CFG_W-1:0] E_ONE             = 9'd256;
  localparam logic [QUO_W-1:0] OUT_MAX           = 24'h7FFFFF;
  localparam logic [QUO_W-1:0] OUT_MIN           = 24'h800000;

  typedef struct packed {
    logic valid;
    logic collided;
    logic zero;
    logic neg_x;
    logic neg_y;
  } ctrl_t;

  function automatic logic [QUO_W-1:0] sat_quot(input logic [QUO_W-1:0] quo,
                                                 input logic ovf, input logic neg);
    logic [QUO_W-1:0] res;
    if (neg) begin
      res = (ovf || quo > OUT_MIN) ? OUT_MIN : (~quo + 24'd1);
    end else begin
      res = (ovf || quo > OUT_MAX) ? OUT_MAX : quo;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/disc_collision_velocity_response.sv
// Top level of the disc collision velocity response: stream ports, restitution register,
// front pipeline, four dividers and the saturating output register. Depends on dcvr_pkg.
//
//  channel   dir   handshake                     payload
//  s_axis    in    s_axis_tvalid/s_axis_tready   one disc pair, 256-bit tdata
//  m_axis    out   m_axis_tvalid/m_axis_tready   four deltas in tdata, collided in tuser
//  cfg       in    cfg_we_i                      restitution, 9 bits
//
// One pair enters per cycle while s_axis_tready is high; each result passes 6 front stages,
// 25 stages of the restoring dividers and one output register. The divider's one-bit-per-stage
// chain sets the depth. Reset clears all valid bits and loads restitution with 0.5 (128).
// When the output register holds an untaken result, every stage holds and s_axis_tready
// falls; nothing is dropped or repeated.
module disc_collision_velocity_response import dcvr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y,
  // mass_a, mass_b, radius_a, radius_b
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // dvel_a_x, dvel_a_y, dvel_b_x, dvel_b_y
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // collided
  output logic                  m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  logic             en;
  logic [CFG_W-1:0] restitution_q;
  ctrl_t            front_ctrl;
  logic [NUM_W-1:0] num_ax, num_ay, num_bx, num_by;
  logic [DEN_W-1:0] den;
  logic [QUO_W-1:0] quo_ax, quo_ay, quo_bx, quo_by;
  logic             ovf_ax, ovf_ay, ovf_bx, ovf_by;
  ctrl_t            ctl_q [0:DIV_STEPS];
  ctrl_t            last;
  logic             apply;
  logic [OUT_DATA_W-1:0] tdata_d, tdata_q;
  logic             valid_q, tuser_q;

  assign en            = !valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restitution_q <= RESTITUTION_RESET;
    end else if (cfg_we_i) begin
      restitution_q <= cfg_wdata_i;
    end
  end

  dcvr_front u_front (
    .clk_i,
    .rst_ni,
    .en_i          (en),
    .valid_i       (s_axis_tvalid),
    .data_i        (s_axis_tdata),
    .restitution_i (restitution_q),
    .ctrl_o        (front_ctrl),
    .num_ax_o      (num_ax),
    .num_ay_o      (num_ay),
    .num_bx_o      (num_bx),
    .num_by_o      (num_by),
    .den_o         (den)
  );

  dcvr_div u_div_ax (.clk_i, .en_i(en), .num_i(num_ax), .den_i(den),
                     .quo_o(quo_ax), .ovf_o(ovf_ax));
  dcvr_div u_div_ay (.clk_i, .en_i(en), .num_i(num_ay), .den_i(den),
                     .quo_o(quo_ay), .ovf_o(ovf_ay));
  dcvr_div u_div_bx (.clk_i, .en_i(en), .num_i(num_bx), .den_i(den),
                     .quo_o(quo_bx), .ovf_o(ovf_bx));
  dcvr_div u_div_by (.clk_i, .en_i(en), .num_i(num_by), .den_i(den),
                     .quo_o(quo_by), .ovf_o(ovf_by));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= front_ctrl;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  assign last  = ctl_q[DIV_STEPS];
  assign apply = last.collided && !last.zero;

  always_comb begin
    tdata_d = '0;
    if (apply) begin
      tdata_d = {sat_quot(quo_by, ovf_by, !last.neg_y),
                 sat_quot(quo_bx, ovf_bx, !last.neg_x),
                 sat_quot(quo_ay, ovf_ay, last.neg_y),
                 sat_quot(quo_ax, ovf_ax, last.neg_x)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= tdata_d;
      tuser_q <= last.collided;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

endmodule

>>> rtl/core/dcvr_front.sv
// Front pipeline: differences, dot products, overlap test and numerator/denominator build.
// Depends on dcvr_pkg; six register stages feeding the dividers.
module dcvr_front import dcvr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [IN_DATA_W-1:0] data_i,
  input  logic [CFG_W-1:0]     restitution_i,
  output ctrl_t                ctrl_o,
  output logic [NUM_W-1:0]     num_ax_o,
  output logic [NUM_W-1:0]     num_ay_o,
  output logic [NUM_W-1:0]     num_bx_o,
  output logic [NUM_W-1:0]     num_by_o,
  output logic [DEN_W-1:0]     den_o
);

  logic [23:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
  logic [15:0] ma, mb, ra, rb;

  assign pax = data_i[23:0];
  assign pay = data_i[47:24];
  assign pbx = data_i[71:48];
  assign pby = data_i[95:72];
  assign vax = data_i[119:96];
  assign vay = data_i[143:120];
  assign vbx = data_i[167:144];
  assign vby = data_i[191:168];
  assign ma  = data_i[207:192];
  assign mb  = data_i[223:208];
  assign ra  = data_i[239:224];
  assign rb  = data_i[255:240];

  // stage 1
  logic               v1_q;
  logic signed [24:0] dx1_d, dy1_d, dvx1_d, dvy1_d, dx1_q, dy1_q, dvx1_q, dvy1_q;
  logic [16:0]        rsum1_d, msum1_d, rsum1_q, msum1_q;
  logic [9:0]         em1_d, em1_q;
  logic [15:0]        ma1_q, mb1_q;

  assign dx1_d   = $signed({pbx[23], pbx}) - $signed({pax[23], pax});
  assign dy1_d   = $signed({pby[23], pby}) - $signed({pay[23], pay});
  assign dvx1_d  = $signed({vbx[23], vbx}) - $signed({vax[23], vax});
  assign dvy1_d  = $signed({vby[23], vby}) - $signed({vay[23], vay});
  assign rsum1_d = {1'b0, ra} + {1'b0, rb};
  assign msum1_d = {1'b0, ma} + {1'b0, mb};
  assign em1_d   = (restitution_i > E_ONE) ? {E_ONE, 1'b0}
                                           : ({1'b0, E_ONE} + {1'b0, restitution_i});

  // stage 2
  logic               v2_q;
  logic signed [49:0] dxx2_d, dyy2_d, sx2_d, sy2_d, sx2_q, sy2_q;
  logic [48:0]        dxx2_q, dyy2_q;
  logic [33:0]        rr2_d, rr2_q;
  logic signed [24:0] dx2_q, dy2_q;
  logic [16:0]        msum2_q;
  logic [9:0]         em2_q;
  logic [15:0]        ma2_q, mb2_q;

  assign dxx2_d = dx1_q * dx1_q;
  assign dyy2_d = dy1_q * dy1_q;
  assign sx2_d  = dx1_q * dvx1_q;
  assign sy2_d  = dy1_q * dvy1_q;
  assign rr2_d  = rsum1_q * rsum1_q;

  // stage 3
  logic               v3_q, c3_q, z3_q, nx3_q, ny3_q;
  logic [49:0]        q3_d;
  logic signed [50:0] s3_d, sabs3_d;
  logic signed [24:0] adx3_d, ady3_d;
  logic [25:0]        ka3_d, kb3_d;
  logic [33:0]        q3_q;
  logic [41:0]        sabs3_q;
  logic [16:0]        adx3_q, ady3_q, msum3_q;
  logic [24:0]        ka3_q, kb3_q;

  assign q3_d    = {1'b0, dxx2_q} + {1'b0, dyy2_q};
  assign s3_d    = $signed({sx2_q[49], sx2_q}) + $signed({sy2_q[49], sy2_q});
  assign sabs3_d = s3_d[50] ? -s3_d : s3_d;
  assign adx3_d  = dx2_q[24] ? -dx2_q : dx2_q;
  assign ady3_d  = dy2_q[24] ? -dy2_q : dy2_q;
  assign ka3_d   = em2_q * mb2_q;
  assign kb3_d   = em2_q * ma2_q;

  // stage 4
  logic               v4_q, c4_q, z4_q, nx4_q, ny4_q;
  logic [50:0]        den4_d, den4_q;
  logic [58:0]        tx4_d, ty4_d, tx4_q, ty4_q;
  logic [24:0]        ka4_q, kb4_q;

  assign den4_d = msum3_q * q3_q;
  assign tx4_d  = sabs3_q * adx3_q;
  assign ty4_d  = sabs3_q * ady3_q;

  // stage 5
  logic               v5_q, c5_q, z5_q, nx5_q, ny5_q;
  logic [50:0]        den5_q;
  logic [54:0]        axl_d, ayl_d, bxl_d, byl_d, axl_q, ayl_q, bxl_q, byl_q;
  logic [53:0]        axh_d, ayh_d, bxh_d, byh_d, axh_q, ayh_q, bxh_q, byh_q;

  assign axl_d = ka4_q * tx4_q[29:0];
  assign axh_d = ka4_q * tx4_q[58:30];
  assign ayl_d = ka4_q * ty4_q[29:0];
  assign ayh_d = ka4_q * ty4_q[58:30];
  assign bxl_d = kb4_q * tx4_q[29:0];
  assign bxh_d = kb4_q * tx4_q[58:30];
  assign byl_d = kb4_q * ty4_q[29:0];
  assign byh_d = kb4_q * ty4_q[58:30];

  // stage 6
  logic             v6_q, c6_q, z6_q, nx6_q, ny6_q;
  logic [NUM_W-1:0] nax6_q, nay6_q, nbx6_q, nby6_q;
  logic [DEN_W-1:0] den6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q   <= dx1_d;
      dy1_q   <= dy1_d;
      dvx1_q  <= dvx1_d;
      dvy1_q  <= dvy1_d;
      rsum1_q <= rsum1_d;
      msum1_q <= msum1_d;
      em1_q   <= em1_d;
      ma1_q   <= ma;
      mb1_q   <= mb;

      dxx2_q  <= dxx2_d[48:0];
      dyy2_q  <= dyy2_d[48:0];
      sx2_q   <= sx2_d;
      sy2_q   <= sy2_d;
      rr2_q   <= rr2_d;
      dx2_q   <= dx1_q;
      dy2_q   <= dy1_q;
      msum2_q <= msum1_q;
      em2_q   <= em1_q;
      ma2_q   <= ma1_q;
      mb2_q   <= mb1_q;

      c3_q    <= q3_d < {16'd0, rr2_q};
      z3_q    <= (q3_d == 50'd0) || (msum2_q == 17'd0);
      nx3_q   <= s3_d[50] ^ dx2_q[24];
      ny3_q   <= s3_d[50] ^ dy2_q[24];
      q3_q    <= q3_d[33:0];
      sabs3_q <= sabs3_d[41:0];
      adx3_q  <= adx3_d[16:0];
      ady3_q  <= ady3_d[16:0];
      msum3_q <= msum2_q;
      ka3_q   <= ka3_d[24:0];
      kb3_q   <= kb3_d[24:0];

      c4_q    <= c3_q;
      z4_q    <= z3_q;
      nx4_q   <= nx3_q;
      ny4_q   <= ny3_q;
      den4_q  <= den4_d;
      tx4_q   <= tx4_d;
      ty4_q   <= ty4_d;
      ka4_q   <= ka3_q;
      kb4_q   <= kb3_q;

      c5_q    <= c4_q;
      z5_q    <= z4_q;
      nx5_q   <= nx4_q;
      ny5_q   <= ny4_q;
      den5_q  <= den4_q;
      axl_q   <= axl_d;
      axh_q   <= axh_d;
      ayl_q   <= ayl_d;
      ayh_q   <= ayh_d;
      bxl_q   <= bxl_d;
      bxh_q   <= bxh_d;
      byl_q   <= byl_d;
      byh_q   <= byh_d;

      c6_q    <= c5_q;
      z6_q    <= z5_q;
      nx6_q   <= nx5_q;
      ny6_q   <= ny5_q;
      den6_q  <= {den5_q, 8'd0};
      nax6_q  <= {axh_q, 30'd0} + {29'd0, axl_q};
      nay6_q  <= {ayh_q, 30'd0} + {29'd0, ayl_q};
      nbx6_q  <= {bxh_q, 30'd0} + {29'd0, bxl_q};
      nby6_q  <= {byh_q, 30'd0} + {29'd0, byl_q};
    end
  end

  assign ctrl_o   = '{valid: v6_q, collided: c6_q, zero: z6_q, neg_x: nx6_q, neg_y: ny6_q};
  assign num_ax_o = nax6_q;
  assign num_ay_o = nay6_q;
  assign num_bx_o = nbx6_q;
  assign num_by_o = nby6_q;
  assign den_o    = den6_q;

endmodule

>>> rtl/core/dcvr_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per register stage.
// Depends on dcvr_pkg for the numerator, denominator and quotient widths.
module dcvr_div import dcvr_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  logic [DEN_W-1:0] rem_q [0:DIV_STEPS];
  logic [DEN_W-1:0] den_q [0:DIV_STEPS];
  logic [QUO_W-1:0] low_q [0:DIV_STEPS];
  logic [QUO_W-1:0] quo_q [0:DIV_STEPS];
  logic             ovf_q [0:DIV_STEPS];

  logic [NUM_W-QUO_W-1:0] head;

  assign head = num_i[NUM_W-1:QUO_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= head >= {1'b0, den_i};
      rem_q[0] <= head[DEN_W-1:0];
      den_q[0] <= den_i;
      low_q[0] <= num_i[QUO_W-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_q[k-1], low_q[k-1][QUO_W-1]};
    assign diff  = trial - {1'b0, den_q[k-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_q[k] <= den_q[k-1];
        low_q[k] <= {low_q[k-1][QUO_W-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][QUO_W-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS];
  assign ovf_o = ovf_q[DIV_STEPS];

endmodule
